// File: hw/rtl/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg: shared types and constants for the positional ordered list
// Item formats, request kind codes, cell commands and controller states.
// ----------------------------------------------------------------------------
package pol_pkg;

   localparam int DEFAULT_DEPTH = 16;

   // Widest cell index and list length over the supported depth range.
   localparam int IDX_MAX_W = 8;
   localparam int LEN_MAX_W = 9;

   localparam logic [2:0] KIND_INSERT = 3'd0;
   localparam logic [2:0] KIND_REMOVE = 3'd1;
   localparam logic [2:0] KIND_GET    = 3'd2;
   localparam logic [2:0] KIND_SET    = 3'd3;
   localparam logic [2:0] KIND_FIND   = 3'd4;
   localparam logic [2:0] KIND_CLEAR  = 3'd5;

   typedef struct packed {
      logic [2:0]         kind;
      logic [4:0]         position;
      logic signed [31:0] new_value;
   } req_item_type;

   typedef struct packed {
      logic               ok;
      logic signed [31:0] read_value;
      logic [3:0]         found_position;
      logic [4:0]         list_length;
   } rsp_item_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_SET,
      CELL_PROBE_GET,
      CELL_PROBE_FIND,
      CELL_SCAN
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type           cmd;
      logic [4:0]             position;
      logic [31:0]            value;
      logic [LEN_MAX_W-1:0]   length;
   } cell_ctrl_type;

   typedef struct packed {
      logic                 found;
      logic [31:0]          value;
      logic [IDX_MAX_W-1:0] index;
   } carry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } fsm_state_type;

endpackage

// File: hw/rtl/positional_ordered_list.sv
// ----------------------------------------------------------------------------
// positional_ordered_list: ordered list of signed 32-bit values
// A chain of DEPTH cells with insert, remove, get, set, find and clear.
// ----------------------------------------------------------------------------
// Insert, remove, set, clear and unused kinds load the result register when accepted, and such
// items can be accepted back to back while the result register drains. For get
// and find, every cell checks itself in the accept cycle, then the first hit
// ripples up the cell chain one cell per cycle, and the result is registered
// in the finish state once the result register is free. No item is accepted
// while a lookup is in progress. There is no clearing pass after reset;
// entries at or above the current length are never read.
module positional_ordered_list #(
   parameter int DEPTH = pol_pkg::DEFAULT_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pol_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pol_pkg::rsp_item_type rsp_item
);
   import pol_pkg::*;

   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int CNT_W = $clog2(DEPTH);

   fsm_state_type   state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic            find_ff, find_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_item_type    rsp_item_ff, rsp_item_in;

   cell_ctrl_type   ctl;
   logic [31:0]     entry_q [DEPTH];
   carry_type       carry_q [DEPTH];

   logic            req_accept;
   logic            rsp_free;
   logic            scan_done;
   logic            finish_load;
   logic [31:0]     pos_w, len_w, len_in_w, depth_w;
   logic            ins_ok, in_range;
   carry_type       top_carry;

   assign pos_w      = 32'(req_item.position);
   assign len_w      = 32'(len_ff);
   assign len_in_w   = 32'(len_in);
   assign depth_w    = 32'(DEPTH);
   assign ins_ok     = (pos_w <= len_w) && (len_w < depth_w);
   assign in_range   = pos_w < len_w;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign scan_done  = cnt_ff == CNT_W'(DEPTH - 1);
   assign top_carry  = carry_q[DEPTH-1];

   // Controller outputs.
   always_comb begin
      req_stall    = 1'b1;
      finish_load  = 1'b0;
      ctl.cmd      = CELL_HOLD;
      ctl.position = req_item.position;
      ctl.value    = req_item.new_value;
      ctl.length   = LEN_MAX_W'(len_ff);
      case (state_ff)
         ST_IDLE: begin
            req_stall = rsp_valid_ff && rsp_stall;
            if (req_valid && !req_stall) begin
               case (req_item.kind)
                  KIND_INSERT: ctl.cmd = ins_ok ? CELL_INSERT : CELL_HOLD;
                  KIND_REMOVE: ctl.cmd = in_range ? CELL_REMOVE : CELL_HOLD;
                  KIND_SET:    ctl.cmd = in_range ? CELL_SET : CELL_HOLD;
                  KIND_GET:    ctl.cmd = CELL_PROBE_GET;
                  KIND_FIND:   ctl.cmd = CELL_PROBE_FIND;
                  default:     ctl.cmd = CELL_HOLD;
               endcase
            end
         end
         ST_SCAN: begin
            ctl.cmd = CELL_SCAN;
         end
         ST_FINISH: begin
            finish_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // Controller next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept &&
                (req_item.kind == KIND_GET || req_item.kind == KIND_FIND)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Length, scan counter and result register.
   always_comb begin
      logic imm_load;
      logic imm_ok;

      len_in       = len_ff;
      find_in      = find_ff;
      cnt_in       = cnt_ff;
      imm_load     = 1'b0;
      imm_ok       = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;

      if (state_ff == ST_SCAN) begin
         cnt_in = cnt_ff + 1'b1;
      end

      if (state_ff == ST_IDLE && req_accept) begin
         cnt_in   = '0;
         imm_load = 1'b1;
         case (req_item.kind)
            KIND_INSERT: begin
               imm_ok = ins_ok;
               if (ins_ok) begin
                  len_in = len_ff + 1'b1;
               end
            end
            KIND_REMOVE: begin
               imm_ok = in_range;
               if (in_range) begin
                  len_in = len_ff - 1'b1;
               end
            end
            KIND_SET: begin
               imm_ok = in_range;
            end
            KIND_CLEAR: begin
               imm_ok = 1'b1;
               len_in = '0;
            end
            KIND_GET: begin
               imm_load = 1'b0;
               find_in  = 1'b0;
            end
            KIND_FIND: begin
               imm_load = 1'b0;
               find_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (imm_load) begin
         rsp_valid_in               = 1'b1;
         rsp_item_in.ok             = imm_ok;
         rsp_item_in.read_value     = '0;
         rsp_item_in.found_position = '0;
         rsp_item_in.list_length    = len_in_w[4:0];
      end else if (finish_load) begin
         rsp_valid_in               = 1'b1;
         rsp_item_in.ok             = top_carry.found;
         rsp_item_in.read_value     = '0;
         rsp_item_in.found_position = '0;
         rsp_item_in.list_length    = len_w[4:0];
         if (top_carry.found) begin
            if (find_ff) begin
               rsp_item_in.found_position = top_carry.index[3:0];
            end else begin
               rsp_item_in.read_value = top_carry.value;
            end
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      cnt_ff      <= cnt_in;
      find_ff     <= find_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [31:0] prev_e;
      logic [31:0] next_e;
      carry_type   prev_c;

      if (i == 0) begin : g_first
         assign prev_e = '0;
         assign prev_c = '0;
      end else begin : g_inner
         assign prev_e = entry_q[i-1];
         assign prev_c = carry_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_e = '0;
      end else begin : g_lower
         assign next_e = entry_q[i+1];
      end

      pol_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .prev_carry (prev_c),
         .entry      (entry_q[i]),
         .carry      (carry_q[i])
      );
   end

   // The list never holds more than DEPTH entries.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_w <= depth_w)
      else $error("list length exceeds depth");

   // No item is taken while a lookup is rippling through the chain.
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("item accepted during a lookup");

   // The length only changes when an item is accepted.
   a_len_stable: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(len_ff))
      else $error("length changed without an item");

   // A lookup result is only loaded once the ripple has covered every cell.
   a_finish_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> $past(state_ff) == ST_SCAN || $past(state_ff) == ST_FINISH)
      else $error("lookup finished without a full scan");

endmodule

// File: hw/rtl/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell: one list entry
// Holds one entry, shifts with its neighbors on insert and remove, and passes
// the first hit of a lookup up the chain one cell per cycle.
// ----------------------------------------------------------------------------
module pol_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pol_pkg::cell_ctrl_type ctl,
   input  logic [31:0]           prev_entry,
   input  logic [31:0]           next_entry,
   input  pol_pkg::carry_type    prev_carry,
   output logic [31:0]           entry,
   output pol_pkg::carry_type    carry
);
   import pol_pkg::*;

   logic [31:0] entry_ff, entry_in;
   logic        hit_ff, hit_in;
   carry_type   carry_ff, carry_in;
   logic [31:0] idx_w, pos_w, len_w;

   assign idx_w = 32'(INDEX);
   assign pos_w = 32'(ctl.position);
   assign len_w = 32'(ctl.length);

   always_comb begin
      entry_in = entry_ff;
      hit_in   = hit_ff;
      carry_in = carry_ff;
      case (ctl.cmd)
         CELL_INSERT: begin
            if (idx_w > pos_w) begin
               entry_in = prev_entry;
            end else if (idx_w == pos_w) begin
               entry_in = ctl.value;
            end
         end
         CELL_REMOVE: begin
            if (idx_w >= pos_w) begin
               entry_in = next_entry;
            end
         end
         CELL_SET: begin
            if (idx_w == pos_w) begin
               entry_in = ctl.value;
            end
         end
         CELL_PROBE_GET: begin
            hit_in         = (idx_w == pos_w) && (idx_w < len_w);
            carry_in.found = 1'b0;
         end
         CELL_PROBE_FIND: begin
            hit_in         = (idx_w < len_w) && (entry_ff == ctl.value);
            carry_in.found = 1'b0;
         end
         CELL_SCAN: begin
            // A hit further down the chain has priority over this cell.
            if (prev_carry.found) begin
               carry_in = prev_carry;
            end else if (hit_ff) begin
               carry_in.found = 1'b1;
               carry_in.value = entry_ff;
               carry_in.index = IDX_MAX_W'(INDEX);
            end else begin
               carry_in.found = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff       <= entry_in;
      carry_ff.value <= carry_in.value;
      carry_ff.index <= carry_in.index;
      if (reset) begin
         hit_ff         <= 1'b0;
         carry_ff.found <= 1'b0;
      end else begin
         hit_ff         <= hit_in;
         carry_ff.found <= carry_in.found;
      end
   end

   assign entry = entry_ff;
   assign carry = carry_ff;

endmodule
